// File: src/linear_blend_skinning_unit_macros.svh
// Assertion macros shared by the skinning unit RTL.
`ifndef LINEAR_BLEND_SKINNING_UNIT_MACROS_SVH
`define LINEAR_BLEND_SKINNING_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LBS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/lbs_pkg.sv
// Shared constants, request types and datapath control for the skinning unit.
`default_nettype none

package lbs_pkg;

    localparam int NUM_JOINTS      = 64;
    localparam int MATRIX_ELEMENTS = 12;
    localparam int ENTRIES         = NUM_JOINTS * MATRIX_ELEMENTS;
    localparam int ADDR_W          = $clog2(ENTRIES);

    // Mode codes of an input request.
    localparam logic MODE_LOAD      = 1'b0;
    localparam logic MODE_INFLUENCE = 1'b1;

    // Input request: either a matrix element write or one vertex influence.
    typedef struct packed {
        logic               mode;
        logic [5:0]         joint_index;
        logic [3:0]         element_index;
        logic signed [31:0] element_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        weight;
        logic               last_influence;
    } t_in_req;

    // Output request: the blended vertex position.
    typedef struct packed {
        logic signed [31:0] skinned_x;
        logic signed [31:0] skinned_y;
        logic signed [31:0] skinned_z;
    } t_out_req;

    // Operand selection of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_X,
        MUL_Y,
        MUL_Z,
        MUL_WEIGHT
    } t_mul_sel;

    // Control word from the sequencer to the datapath.
    typedef struct packed {
        t_mul_sel   mul_sel;
        logic       sum_load;
        logic       sum_add;
        logic       m3_capture;
        logic       t_capture;
        logic       acc_add;
        logic [1:0] acc_row;
        logic       acc_clear;
    } t_dp_ctrl;

endpackage

`default_nettype wire

// File: src/lbs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/lbs_datapath.sv
// Shared multiplier, row sum, row saturation and the three blend accumulators.
`default_nettype none

module lbs_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lbs_pkg::t_dp_ctrl  i_ctrl,
    input  wire logic signed [31:0] i_mat,
    input  wire lbs_pkg::t_in_req   i_req,
    output lbs_pkg::t_out_req       o_res
);

    localparam logic signed [50:0] ROW_MAX = 51'sd2147483647;
    localparam logic signed [50:0] ROW_MIN = -51'sd2147483648;
    localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [65:0] r_prod;
    logic signed [65:0] r_sum;
    logic signed [31:0] r_m3;
    logic signed [31:0] r_t;
    logic signed [63:0] r_acc [3];
    logic signed [50:0] row_wide;
    logic signed [31:0] row_sat;
    logic signed [64:0] acc_wide;
    logic signed [63:0] acc_sat;

    // Saturate floor(acc / 2^15) to the signed 32-bit range.
    function automatic logic signed [31:0] out_sat(input logic signed [63:0] a);
        logic signed [48:0] s;
        logic signed [31:0] r;
        s = a[63:15];
        if (s > 49'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (s < -49'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_ctrl.mul_sel)
            lbs_pkg::MUL_X: begin
                mul_a = {i_mat[31], i_mat};
                mul_b = {i_req.pos_x[31], i_req.pos_x};
            end
            lbs_pkg::MUL_Y: begin
                mul_a = {i_mat[31], i_mat};
                mul_b = {i_req.pos_y[31], i_req.pos_y};
            end
            lbs_pkg::MUL_Z: begin
                mul_a = {i_mat[31], i_mat};
                mul_b = {i_req.pos_z[31], i_req.pos_z};
            end
            lbs_pkg::MUL_WEIGHT: begin
                mul_a = {17'b0, i_req.weight};
                mul_b = {r_t[31], r_t};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Row result: floor(sum / 2^16) plus the translation term, saturated to Q16.16.
    always_comb begin
        row_wide = {r_sum[65], r_sum[65:16]} + {{19{r_m3[31]}}, r_m3};
        if (row_wide > ROW_MAX) begin
            row_sat = 32'sh7FFFFFFF;
        end else if (row_wide < ROW_MIN) begin
            row_sat = 32'sh80000000;
        end else begin
            row_sat = row_wide[31:0];
        end
    end

    // Saturating add of the weighted row into the selected accumulator.
    always_comb begin
        acc_wide = {r_acc[i_ctrl.acc_row][63], r_acc[i_ctrl.acc_row]}
                 + {{16{r_prod[48]}}, r_prod[48:0]};
        if (acc_wide[64] != acc_wide[63]) begin
            acc_sat = acc_wide[64] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_sat = acc_wide[63:0];
        end
    end

    // Product, sum and row operand registers.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (i_ctrl.sum_load) begin
            r_sum <= r_prod;
        end else if (i_ctrl.sum_add) begin
            r_sum <= r_sum + r_prod;
        end
        if (i_ctrl.m3_capture) begin
            r_m3 <= i_mat;
        end
        if (i_ctrl.t_capture) begin
            r_t <= row_sat;
        end
    end

    // Accumulators clear at reset and after each emitted vertex.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.acc_clear) begin
            r_acc[0] <= '0;
            r_acc[1] <= '0;
            r_acc[2] <= '0;
        end else if (i_ctrl.acc_add) begin
            r_acc[i_ctrl.acc_row] <= acc_sat;
        end
    end

    assign o_res.skinned_x = out_sat(r_acc[0]);
    assign o_res.skinned_y = out_sat(r_acc[1]);
    assign o_res.skinned_z = out_sat(r_acc[2]);

endmodule

`default_nettype wire

// File: src/linear_blend_skinning_unit.sv
// Linear blend skinning unit: joint matrix store, sequencer and result register.
//
// Input channel (i_in_valid, o_in_stall, i_in_req) takes two kinds of request.
// A load request writes one element of a joint's 3x4 Q16.16 matrix and is
// taken without stalling the input. An influence request transforms the rest
// position by the joint's matrix, weights it and adds it into three accumulators;
// once accepted it stalls the input until it returns to idle: it runs 24 steps
// (three rows of eight steps on the one shared 33x33 multiplier and the
// single matrix read port) and then a finishing state. An influence with a joint
// outside the table goes straight to the finishing state and adds nothing.
// When the influence is flagged last, the saturated x, y, z are loaded into
// the output register in the finishing cycle and appear on o_out_valid /
// o_out_req the cycle after; the accumulators clear at the same time.
// A result waiting under i_out_stall does not block load requests or the
// next influence computation; only the next result waits for the register.
// Reset clears the sequencer, the accumulators and the output valid; the
// matrix store is not cleared and must be loaded before use.
`default_nettype none

`include "linear_blend_skinning_unit_macros.svh"

module linear_blend_skinning_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire lbs_pkg::t_in_req  i_in_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output lbs_pkg::t_out_req      o_out_req
);

    localparam int         ADDR_W    = lbs_pkg::ADDR_W;
    localparam logic [4:0] LAST_STEP = 5'd23;

    // Step positions within one matrix row.
    localparam logic [2:0] K_MUL_X = 3'd1;
    localparam logic [2:0] K_MUL_Y = 3'd2;
    localparam logic [2:0] K_MUL_Z = 3'd3;
    localparam logic [2:0] K_M3    = 3'd4;
    localparam logic [2:0] K_ROW   = 3'd5;
    localparam logic [2:0] K_MUL_W = 3'd6;
    localparam logic [2:0] K_ACC   = 3'd7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [4:0]         r_step, n_step;
    logic [ADDR_W-1:0]  r_base, n_base;
    lbs_pkg::t_in_req   r_req, n_req;
    logic               r_out_valid, n_out_valid;
    lbs_pkg::t_out_req  r_out, n_out;

    logic               in_accept;
    logic               joint_ok;
    logic               elem_ok;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [31:0]        ram_rdata;
    logic [2:0]         k;
    logic [1:0]         row;
    logic               emit;
    lbs_pkg::t_dp_ctrl  ctrl;
    lbs_pkg::t_out_req  dp_res;

    // Input handshake and matrix write decode.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign joint_ok   = int'(i_in_req.joint_index) < lbs_pkg::NUM_JOINTS;
    assign elem_ok    = int'(i_in_req.element_index) < lbs_pkg::MATRIX_ELEMENTS;
    assign ram_we     = in_accept && (i_in_req.mode == lbs_pkg::MODE_LOAD)
                        && joint_ok && elem_ok;
    assign ram_waddr  = ADDR_W'(int'(i_in_req.joint_index) * lbs_pkg::MATRIX_ELEMENTS
                                + int'(i_in_req.element_index));

    // Sequencer step split into row and position within the row.
    assign k         = r_step[2:0];
    assign row       = r_step[4:3];
    assign ram_raddr = r_base + ADDR_W'({row, k[1:0]});

    lbs_ram #(
        .WIDTH (32),
        .DEPTH (lbs_pkg::ENTRIES)
    ) u_matrix_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_req.element_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A result leaves the finishing cycle once the output register can take it.
    assign emit = (r_state == S_DONE) && r_req.last_influence
                  && !(r_out_valid && i_out_stall);

    // Datapath control decoded from the step counter.
    always_comb begin
        ctrl           = '0;
        ctrl.mul_sel   = lbs_pkg::MUL_X;
        ctrl.acc_row   = row;
        ctrl.acc_clear = emit;
        if (r_state == S_RUN) begin
            case (k)
                K_MUL_X: begin
                    ctrl.mul_sel = lbs_pkg::MUL_X;
                end
                K_MUL_Y: begin
                    ctrl.mul_sel  = lbs_pkg::MUL_Y;
                    ctrl.sum_load = 1'b1;
                end
                K_MUL_Z: begin
                    ctrl.mul_sel = lbs_pkg::MUL_Z;
                    ctrl.sum_add = 1'b1;
                end
                K_M3: begin
                    ctrl.sum_add    = 1'b1;
                    ctrl.m3_capture = 1'b1;
                end
                K_ROW: begin
                    ctrl.t_capture = 1'b1;
                end
                K_MUL_W: begin
                    ctrl.mul_sel = lbs_pkg::MUL_WEIGHT;
                end
                K_ACC: begin
                    ctrl.acc_add = 1'b1;
                end
                default: begin
                    ctrl.mul_sel = lbs_pkg::MUL_X;
                end
            endcase
        end
    end

    lbs_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_mat   (ram_rdata),
        .i_req   (r_req),
        .o_res   (dp_res)
    );

    // Next-state logic of the sequencer and the output register.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_base      = r_base;
        n_req       = r_req;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (in_accept && (i_in_req.mode == lbs_pkg::MODE_INFLUENCE)) begin
                    n_req   = i_in_req;
                    n_base  = ADDR_W'(int'(i_in_req.joint_index)
                                      * lbs_pkg::MATRIX_ELEMENTS);
                    n_state = joint_ok ? S_RUN : S_DONE;
                end
            end
            S_RUN: begin
                if (r_step == LAST_STEP) begin
                    n_step  = '0;
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            S_DONE: begin
                if (!r_req.last_influence) begin
                    n_state = S_IDLE;
                end else if (emit) begin
                    n_out_valid = 1'b1;
                    n_out       = dp_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        r_base <= n_base;
        r_req  <= n_req;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // Checks on the sequencer and the result path.
    `LBS_ASSERT_NEXT(a_emit_sets_valid, i_clk, i_rst_n, emit, o_out_valid, "result lost on emit")
    `LBS_ASSERT_SAME(a_idle_step_zero, i_clk, i_rst_n, r_state == S_IDLE, r_step == 5'd0, "step not cleared in idle")
    `LBS_ASSERT_SAME(a_step_bound, i_clk, i_rst_n, r_state == S_RUN, r_step <= LAST_STEP, "step past schedule")
    `LBS_ASSERT_SAME(a_write_only_load, i_clk, i_rst_n, ram_we, r_state == S_IDLE && i_in_req.mode == lbs_pkg::MODE_LOAD, "matrix write outside load")

endmodule

`default_nettype wire
